[rtl/mme_pkg.sv]
// Package for the modular exponentiation core: widths, reset values,
// register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package mme_pkg;

   // fixed field widths of the stream and register ports
   localparam int FIELD_W       = 64;
   localparam int BYTE_W        = 8;
   localparam int REQ_TDATA_W   = FIELD_W;
   localparam int RSP_TDATA_W   = FIELD_W + BYTE_W;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 4;

   localparam int KEY_WIDTH_DEFAULT = 64;

   localparam logic [FIELD_W-1:0] MODULUS_RESET  = 64'd3233;
   localparam logic [FIELD_W-1:0] EXPONENT_RESET = 64'd2753;
   localparam logic [BYTE_W-1:0]  BYTE_MASK      = 8'hFF;

   // register index, taken from paddr[3] (registers sit 8 bytes apart)
   localparam logic REG_MODULUS  = 1'b0;
   localparam logic REG_EXPONENT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LAUNCH = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_WRAP   = 4'b1000
   } state_type;

endpackage : mme_pkg

`default_nettype wire

[rtl/mme_csr.sv]
// APB-style register file holding the modulus and the exponent.
// Depends on mme_pkg.
`default_nettype none

module mme_csr
   import mme_pkg::*;
#(
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic [KEY_WIDTH-1:0]  modulus,
   output      logic [KEY_WIDTH-1:0]  exponent
);

   logic [KEY_WIDTH-1:0] modulus_ff,  modulus_in;
   logic [KEY_WIDTH-1:0] exponent_ff, exponent_in;
   logic                 wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (wr_en) begin
         unique case (csr_paddr[3])
            REG_MODULUS:  modulus_in  = csr_pwdata[KEY_WIDTH-1:0];
            REG_EXPONENT: exponent_in = csr_pwdata[KEY_WIDTH-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= MODULUS_RESET[KEY_WIDTH-1:0];
         exponent_ff <= EXPONENT_RESET[KEY_WIDTH-1:0];
      end else begin
         modulus_ff  <= modulus_in;
         exponent_ff <= exponent_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         REG_MODULUS:  csr_prdata = CSR_DATA_W'(modulus_ff);
         REG_EXPONENT: csr_prdata = CSR_DATA_W'(exponent_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign modulus  = modulus_ff;
   assign exponent = exponent_ff;

endmodule : mme_csr

`default_nettype wire

[rtl/mme_modmul.sv]
// Bit-serial modular multiplier: x*y mod m by shift-and-add, one bit of y
// per cycle, with a conditional subtract after each add and each doubling.
// Depends on mme_pkg.
`default_nettype none

module mme_modmul
   import mme_pkg::*;
#(
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [KEY_WIDTH-1:0] x,
   input  wire logic [KEY_WIDTH-1:0] y,
   input  wire logic [KEY_WIDTH-1:0] m,
   output      logic                 busy,
   output      logic                 done,
   output      logic [KEY_WIDTH-1:0] product
);

   localparam int CNT_W = $clog2(KEY_WIDTH + 1);

   logic [KEY_WIDTH-1:0] acc_ff, acc_in;
   logic [KEY_WIDTH-1:0] x_ff,   x_in;
   logic [KEY_WIDTH-1:0] y_ff,   y_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   // (a + b) mod mod for a, b < mod; the carry bit takes part in the compare
   function automatic logic [KEY_WIDTH-1:0] add_mod(
      input logic [KEY_WIDTH-1:0] a,
      input logic [KEY_WIDTH-1:0] b,
      input logic [KEY_WIDTH-1:0] mod
   );
      logic [KEY_WIDTH:0] sum;
      logic [KEY_WIDTH:0] diff;
      sum  = {1'b0, a} + {1'b0, b};
      diff = sum - {1'b0, mod};
      if (sum >= {1'b0, mod}) begin
         add_mod = diff[KEY_WIDTH-1:0];
      end else begin
         add_mod = sum[KEY_WIDTH-1:0];
      end
   endfunction

   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         x_in   = x;
         y_in   = y;
         cnt_in = CNT_W'(KEY_WIDTH);
      end else if (cnt_ff != '0) begin
         if (y_ff[0]) begin
            acc_in = add_mod(acc_ff, x_ff, m);
         end
         x_in    = add_mod(x_ff, x_ff, m);
         y_in    = y_ff >> 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign busy    = (cnt_ff != '0);
   assign done    = done_ff;
   assign product = acc_ff;

endmodule : mme_modmul

`default_nettype wire

[rtl/modular_exponentiation_core.sv]
// Modular exponentiation core: residue = block^exponent mod modulus.
// A good block runs through KEY_WIDTH exponent bits, each one launching both
//   bit-serial multipliers and waiting for them; a block not below modulus goes
//   straight to the response. A new request is taken only once the sequencer is
//   back in idle, after the last response has been placed in the output register.
// Reset: synchronous, active high; registers return to 3233 / 2753.
`default_nettype none

module modular_exponentiation_core
   import mme_pkg::*;
#(
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // [63:0] cipher_block
   // response stream
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,   // [63:0] residue, [71:64] plain_byte
   output      logic                   rsp_tuser,   // [0] bad_block
   // configuration port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [CSR_DATA_W-1:0]  csr_prdata,
   output      logic                   csr_pready
);

   localparam int BIT_CNT_W = $clog2(KEY_WIDTH);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [KEY_WIDTH-1:0] modulus;
   logic [KEY_WIDTH-1:0] exponent;

   mme_csr #(.KEY_WIDTH(KEY_WIDTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .modulus     (modulus),
      .exponent    (exponent)
   );

   assign csr_pready = 1'b1;

   // ------------------------------------------------------------------
   // Sequencer state and working registers
   // ------------------------------------------------------------------
   state_type            state_ff,   state_in;
   logic [KEY_WIDTH-1:0] acc_ff,     acc_in;     // running result
   logic [KEY_WIDTH-1:0] base_ff,    base_in;    // block^(2^i)
   logic [KEY_WIDTH-1:0] exp_ff,     exp_in;     // exponent, shifted right per bit
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 bad_ff,     bad_in;

   // output register, parts the sequencer from the response side
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_WIDTH-1:0] rsp_res_ff,   rsp_res_in;
   logic                 rsp_bad_ff,   rsp_bad_in;

   logic [KEY_WIDTH-1:0] req_block;
   logic                 req_hs;
   logic                 mm_start;
   logic                 mma_busy, mma_done, mmb_busy, mmb_done;
   logic [KEY_WIDTH-1:0] mma_prod, mmb_prod;
   logic                 out_free;

   assign req_block  = req_tdata[KEY_WIDTH-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_hs     = req_tvalid && req_tready;
   assign mm_start   = (state_ff == ST_LAUNCH);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Two multipliers run side by side on each exponent bit:
   //   A forms acc*base (kept only when the bit is set), B forms base*base.
   mme_modmul #(.KEY_WIDTH(KEY_WIDTH)) u_mul_acc (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .x       (acc_ff),
      .y       (base_ff),
      .m       (modulus),
      .busy    (mma_busy),
      .done    (mma_done),
      .product (mma_prod)
   );

   mme_modmul #(.KEY_WIDTH(KEY_WIDTH)) u_mul_sqr (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .x       (base_ff),
      .y       (base_ff),
      .m       (modulus),
      .busy    (mmb_busy),
      .done    (mmb_done),
      .product (mmb_prod)
   );

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      bit_cnt_in   = bit_cnt_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_res_in   = rsp_res_ff;
      rsp_bad_in   = rsp_bad_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_hs) begin
               // modulus of one gives residue zero, so start from zero there
               acc_in     = (modulus == KEY_WIDTH'(1)) ? '0 : KEY_WIDTH'(1);
               base_in    = req_block;
               exp_in     = exponent;
               bit_cnt_in = '0;
               bad_in     = (req_block >= modulus);
               state_in   = (req_block >= modulus) ? ST_WRAP : ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mma_done) begin
               if (exp_ff[0]) begin
                  acc_in = mma_prod;
               end
               base_in    = mmb_prod;
               exp_in     = exp_ff >> 1;
               bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
               state_in   = (bit_cnt_ff == BIT_CNT_W'(KEY_WIDTH - 1)) ? ST_WRAP : ST_LAUNCH;
            end
         end
         ST_WRAP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = bad_ff ? '0 : acc_ff;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      base_ff    <= base_in;
      exp_ff     <= exp_in;
      bad_ff     <= bad_in;
      rsp_res_ff <= rsp_res_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   // ------------------------------------------------------------------
   // Response packing: residue in the low word, its low byte above it
   // ------------------------------------------------------------------
   logic [FIELD_W-1:0] rsp_residue;

   assign rsp_residue = FIELD_W'(rsp_res_ff);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {rsp_residue[BYTE_W-1:0] & BYTE_MASK, rsp_residue};
   assign rsp_tuser   = rsp_bad_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // both multipliers are launched together and must finish together
   a_mul_lockstep: assert property (@(posedge clock) disable iff (reset)
      (mma_done == mmb_done) && (mma_busy == mmb_busy))
      else $error("multipliers out of step");

   // a multiplier is never launched while still working
   a_no_relaunch: assert property (@(posedge clock) disable iff (reset)
      mm_start |-> !mma_busy)
      else $error("multiplier launched while busy");

   // a bad block carries a zero residue
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("bad block with non-zero payload");

   // a good residue is always reduced below the modulus
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_res_ff < modulus))
      else $error("residue not reduced");

endmodule : modular_exponentiation_core

`default_nettype wire
